/* hdl/rational_arithmetic_unit_defines.svh */
// Assertion macros for the rational arithmetic unit.
`ifndef RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH
`define RATIONAL_ARITHMETIC_UNIT_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define RAU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rau check failed");

// Next-cycle implication, disabled in reset.
`define RAU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rau check failed");

// Next-cycle implication, always active.
`define RAU_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rau check failed");

`endif

/* hdl/rau_pkg.sv */
package rau_pkg;

    localparam int CMD_W   = 3;
    localparam int FIELD_W = 32;
    localparam int DEN_W   = 31;

    localparam logic [CMD_W-1:0] CMD_ADD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SUB = 3'd1;
    localparam logic [CMD_W-1:0] CMD_MUL = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DIV = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CMP = 3'd4;

    typedef enum logic [1:0] {
        OP_ADD,
        OP_DIFF,
        OP_MUL,
        OP_DIV
    } t_op;

    typedef enum logic [1:0] {
        ST_OK   = 2'd0,
        ST_ZDEN = 2'd1,
        ST_DIV0 = 2'd2,
        ST_OVF  = 2'd3
    } t_status;

    typedef struct packed {
        t_op  op;
        logic sa;
        logic sb;
        logic zden;
        logic div0;
    } t_cls;

endpackage

/* hdl/rau_if.sv */
interface rau_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  command;
    logic signed [31:0] a_num;
    logic signed [31:0] a_den;
    logic signed [31:0] b_num;
    logic signed [31:0] b_den;

    modport source (output valid, command, a_num, a_den, b_num, b_den, input ready);
    modport sink (input valid, command, a_num, a_den, b_num, b_den, output ready);
endinterface

interface rau_out_if;
    logic        valid;
    logic        ready;
    logic signed [31:0] res_num;
    logic [30:0] res_den;
    logic        greater;
    logic        less;
    logic        equal;
    logic [1:0]  status;

    modport source (output valid, res_num, res_den, greater, less, equal, status,
                    input ready);
    modport sink (input valid, res_num, res_den, greater, less, equal, status,
                  output ready);
endinterface

/* hdl/rau_fifo.sv */
module rau_fifo #(
    parameter int DATA_W = 8,
    parameter int DEPTH  = 2
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  logic [DATA_W-1:0] i_data,
    output logic              o_full,
    output logic              o_valid,
    input  logic              i_pop,
    output logic [DATA_W-1:0] o_data
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     r_rp;
    logic [CW-1:0]     r_cnt;
    logic              w_push;
    logic              w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rp];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_mem[r_wp] <= i_data;
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule

/* hdl/rau_front.sv */
module rau_front
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    rau_in_if.sink       i_in,
    output logic         o_valid,
    input  logic         i_ready,
    output t_cls         o_cls,
    output logic [WIDTH:0] o_an,
    output logic [WIDTH:0] o_ad,
    output logic [WIDTH:0] o_bn,
    output logic [WIDTH:0] o_bd
);
    localparam int M = WIDTH + 1;

    logic an_s, ad_s, bn_s, bd_s;

    function automatic logic [M-1:0] mag(input logic [FIELD_W-1:0] raw);
        logic [WIDTH-1:0] v;
        v = raw[WIDTH-1:0];
        mag = v[WIDTH-1] ? ({1'b0, ~v} + 1'b1) : {1'b0, v};
    endfunction

    assign an_s = i_in.a_num[WIDTH-1];
    assign ad_s = i_in.a_den[WIDTH-1];
    assign bn_s = i_in.b_num[WIDTH-1];
    assign bd_s = i_in.b_den[WIDTH-1];

    assign o_an = mag(i_in.a_num);
    assign o_ad = mag(i_in.a_den);
    assign o_bn = mag(i_in.b_num);
    assign o_bd = mag(i_in.b_den);

    assign o_valid    = i_in.valid;
    assign i_in.ready = i_ready;

    always_comb begin
        o_cls.sa   = (o_an != '0) && (an_s != ad_s);
        o_cls.sb   = (o_bn != '0) && (bn_s != bd_s);
        o_cls.zden = (o_ad == '0) || (o_bd == '0);
        o_cls.div0 = 1'b0;
        unique case (i_in.command)
            CMD_ADD: o_cls.op = OP_ADD;
            CMD_MUL: o_cls.op = OP_MUL;
            CMD_DIV: begin
                o_cls.op   = OP_DIV;
                o_cls.div0 = (o_bn == '0);
            end
            default: o_cls.op = OP_DIFF;
        endcase
    end
endmodule

/* hdl/rau_back.sv */
module rau_back
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  t_cls           i_cls,
    input  logic [WIDTH:0] i_an,
    input  logic [WIDTH:0] i_ad,
    input  logic [WIDTH:0] i_bn,
    input  logic [WIDTH:0] i_bd,
    rau_out_if.source      o_out
);
    localparam int M  = WIDTH + 1;
    localparam int P  = 2 * M;
    localparam int CW = $clog2(P);
    localparam logic [P-1:0] LIM = P'(1) << (WIDTH - 1);

    typedef enum logic [3:0] {
        S_IDLE, S_MUL1, S_MUL2, S_CMP, S_SHIFT, S_GCD, S_DIV, S_CHK, S_OUT
    } t_state;

    t_state        r_state;
    t_cls          r_cls;
    t_status       r_status;
    logic [M-1:0]  r_an, r_ad, r_bn, r_bd;
    logic [P-1:0]  r_p1, r_p2, r_p3, r_p4;
    logic [P-1:0]  r_n, r_d, r_x, r_y, r_rem1, r_rem2;
    logic          r_rs, r_gt, r_lt, r_eq;
    logic [CW-1:0] r_cnt;
    logic          r_ovalid;
    logic signed [31:0] r_res_num;
    logic [DEN_W-1:0]   r_res_den;
    logic          r_ogt, r_olt, r_oeq;
    t_status       r_ostatus;

    logic [P-1:0]  d_m, a_m, c_rn, c_rd, g_diff, c_sn, rem1_n, rem2_n;
    logic          d_s, a_s, c_rs, g_gt, ge1, ge2;
    logic [P:0]    t1, t2;

    always_comb begin
        if (r_cls.sa == !r_cls.sb) begin
            d_m = r_p1 + r_p2;
            d_s = r_cls.sa;
        end else if (r_p1 >= r_p2) begin
            d_m = r_p1 - r_p2;
            d_s = (r_p1 == r_p2) ? 1'b0 : r_cls.sa;
        end else begin
            d_m = r_p2 - r_p1;
            d_s = !r_cls.sb;
        end
        if (r_cls.sa == r_cls.sb) begin
            a_m = r_p1 + r_p2;
            a_s = r_cls.sa;
        end else if (r_p1 >= r_p2) begin
            a_m = r_p1 - r_p2;
            a_s = (r_p1 == r_p2) ? 1'b0 : r_cls.sa;
        end else begin
            a_m = r_p2 - r_p1;
            a_s = r_cls.sb;
        end
        unique case (r_cls.op)
            OP_ADD: begin
                c_rn = a_m;
                c_rs = a_s;
                c_rd = r_p4;
            end
            OP_MUL: begin
                c_rn = r_p3;
                c_rs = (r_p3 != '0) && (r_cls.sa != r_cls.sb);
                c_rd = r_p4;
            end
            OP_DIV: begin
                c_rn = r_p1;
                c_rs = (r_p1 != '0) && (r_cls.sa != r_cls.sb);
                c_rd = r_p2;
            end
            default: begin
                c_rn = d_m;
                c_rs = d_s;
                c_rd = r_p4;
            end
        endcase
    end

    assign g_gt   = (r_x > r_y);
    assign g_diff = g_gt ? (r_x - r_y) : (r_y - r_x);

    assign t1     = {r_rem1, r_n[P-1]};
    assign t2     = {r_rem2, r_d[P-1]};
    assign ge1    = (t1 >= {1'b0, r_x});
    assign ge2    = (t2 >= {1'b0, r_x});
    assign rem1_n = ge1 ? P'(t1 - {1'b0, r_x}) : P'(t1);
    assign rem2_n = ge2 ? P'(t2 - {1'b0, r_x}) : P'(t2);

    assign c_sn = r_rs ? (~r_n + 1'b1) : r_n;

    assign o_ready = (r_state == S_IDLE);

    assign o_out.valid   = r_ovalid;
    assign o_out.res_num = r_res_num;
    assign o_out.res_den = r_res_den;
    assign o_out.greater = r_ogt;
    assign o_out.less    = r_olt;
    assign o_out.equal   = r_oeq;
    assign o_out.status  = r_ostatus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            if (o_out.ready && (r_state != S_OUT)) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cls    <= i_cls;
                        r_an     <= i_an;
                        r_ad     <= i_ad;
                        r_bn     <= i_bn;
                        r_bd     <= i_bd;
                        if (i_cls.zden) begin
                            r_status <= ST_ZDEN;
                            r_gt     <= 1'b0;
                            r_lt     <= 1'b0;
                            r_eq     <= 1'b0;
                            r_state  <= S_OUT;
                        end else begin
                            r_status <= ST_OK;
                            r_state  <= S_MUL1;
                        end
                    end
                end
                S_MUL1: begin
                    r_p1    <= r_an * r_bd;
                    r_p2    <= r_bn * r_ad;
                    r_state <= S_MUL2;
                end
                S_MUL2: begin
                    r_p3    <= r_an * r_bn;
                    r_p4    <= r_ad * r_bd;
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_gt <= (d_m != '0) && !d_s;
                    r_lt <= (d_m != '0) && d_s;
                    r_eq <= (d_m == '0);
                    if (r_cls.div0) begin
                        r_status <= ST_DIV0;
                        r_state  <= S_OUT;
                    end else if (c_rn == '0) begin
                        r_n     <= '0;
                        r_d     <= P'(1);
                        r_rs    <= 1'b0;
                        r_state <= S_CHK;
                    end else begin
                        r_n     <= c_rn;
                        r_d     <= c_rd;
                        r_x     <= c_rn;
                        r_y     <= c_rd;
                        r_rs    <= c_rs;
                        r_state <= S_SHIFT;
                    end
                end
                S_SHIFT: begin
                    // strip common factors of two from all four
                    if (!r_x[0] && !r_y[0]) begin
                        r_x <= r_x >> 1;
                        r_y <= r_y >> 1;
                        r_n <= r_n >> 1;
                        r_d <= r_d >> 1;
                    end else begin
                        r_state <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (r_x == r_y) begin
                        r_rem1  <= '0;
                        r_rem2  <= '0;
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else if (!r_x[0]) begin
                        r_x <= r_x >> 1;
                    end else if (!r_y[0]) begin
                        r_y <= r_y >> 1;
                    end else if (g_gt) begin
                        r_x <= g_diff;
                    end else begin
                        r_y <= g_diff;
                    end
                end
                S_DIV: begin
                    r_n    <= {r_n[P-2:0], ge1};
                    r_d    <= {r_d[P-2:0], ge2};
                    r_rem1 <= rem1_n;
                    r_rem2 <= rem2_n;
                    r_cnt  <= r_cnt + 1'b1;
                    if (r_cnt == CW'(P - 1)) begin
                        r_state <= S_CHK;
                    end
                end
                S_CHK: begin
                    if ((r_n > (r_rs ? LIM : LIM - 1'b1)) || (r_d > LIM - 1'b1)) begin
                        r_status <= ST_OVF;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    if (!r_ovalid || o_out.ready) begin
                        r_ovalid  <= 1'b1;
                        r_ogt     <= r_gt;
                        r_olt     <= r_lt;
                        r_oeq     <= r_eq;
                        r_ostatus <= r_status;
                        if (r_status == ST_OK) begin
                            r_res_num <= 32'(signed'(c_sn[WIDTH-1:0]));
                            r_res_den <= DEN_W'(r_d[WIDTH-2:0]);
                        end else begin
                            r_res_num <= '0;
                            r_res_den <= '0;
                        end
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

/* hdl/rational_arithmetic_unit.sv */
// Rational arithmetic unit: exact add, subtract, multiply, divide and
// compare of two signed fractions, result reduced by the gcd.
// Input channel i_in: command and a_num/a_den/b_num/b_den; a word is
// taken when valid and ready are both high. Only the low WIDTH bits of
// each field are used.
// Output channel o_out: reduced res_num/res_den, greater/less/equal and
// status, one word per input word, in order.
// The time per word depends on the operands: it is set by the binary gcd
// loop and the bit-serial quotient unit. A zero input denominator skips
// the multiplies, gcd and quotient; divide by zero is reported from the
// compare state, and a zero result skips the shift, gcd and quotient.
// The engine works on one word at a time and takes a new word only when
// it is idle.
// A two-word queue sits between the input classifier and the engine, so
// input words are taken while the engine works or a result waits.
// When the receiver stalls, the result is held in the output register
// and the engine waits once it has the next result ready.
// Reset (i_rst_n low, synchronous) empties the queue and the output.
module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int WIDTH = 32
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rau_in_if.sink    i_in,
    rau_out_if.source o_out
);
    localparam int M      = WIDTH + 1;
    localparam int DATA_W = $bits(t_cls) + 4 * M;

    logic          f_valid, f_ready;
    t_cls          f_cls;
    logic [M-1:0]  f_an, f_ad, f_bn, f_bd;
    logic          q_full, q_valid, q_pop;
    logic [DATA_W-1:0] q_data;
    t_cls          b_cls;
    logic [M-1:0]  b_an, b_ad, b_bn, b_bd;

    rau_front #(.WIDTH(WIDTH)) u_front (
        .i_in    (i_in),
        .o_valid (f_valid),
        .i_ready (f_ready),
        .o_cls   (f_cls),
        .o_an    (f_an),
        .o_ad    (f_ad),
        .o_bn    (f_bn),
        .o_bd    (f_bd)
    );

    assign f_ready = !q_full;

    rau_fifo #(.DATA_W(DATA_W), .DEPTH(2)) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  ({f_cls, f_an, f_ad, f_bn, f_bd}),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (q_pop),
        .o_data  (q_data)
    );

    assign {b_cls, b_an, b_ad, b_bn, b_bd} = q_data;

    rau_back #(.WIDTH(WIDTH)) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .o_ready (q_pop),
        .i_cls   (b_cls),
        .i_an    (b_an),
        .i_ad    (b_ad),
        .i_bn    (b_bn),
        .i_bd    (b_bd),
        .o_out   (o_out)
    );
endmodule

/* hdl/rau_checker.sv */
`include "rational_arithmetic_unit_defines.svh"

module rau_checker
    import rau_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [31:0] i_res_num,
    input logic [30:0] i_res_den,
    input logic        i_greater,
    input logic        i_less,
    input logic        i_equal,
    input logic [1:0]  i_status
);
    `RAU_ASSERT_NEXT(a_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid && $stable(i_res_num) && $stable(i_status))
    `RAU_ASSERT_IMP(a_one_flag, i_clk, i_rst_n, i_out_valid, $countones({i_greater, i_less, i_equal}) <= 1)
    `RAU_ASSERT_IMP(a_err_zero, i_clk, i_rst_n, i_out_valid && (i_status != ST_OK), (i_res_num == '0) && (i_res_den == '0))
    `RAU_ASSERT_IMP(a_ok_den, i_clk, i_rst_n, i_out_valid && (i_status == ST_OK), i_res_den != '0)
    `RAU_ASSERT_NEXT_ALWAYS(a_rst, i_clk, !i_rst_n, !i_out_valid)
endmodule

bind rational_arithmetic_unit rau_checker u_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_res_num   (o_out.res_num),
    .i_res_den   (o_out.res_den),
    .i_greater   (o_out.greater),
    .i_less      (o_out.less),
    .i_equal     (o_out.equal),
    .i_status    (o_out.status)
);

/* tb/testbench.sv */
module testbench;
    import rau_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [2:0]         command;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } t_operands;

    typedef struct {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               greater;
        logic               less;
        logic               equal;
        logic [1:0]         status;
    } t_fraction_result;

    logic i_clk;
    logic i_rst_n;
    rau_in_if  in_ch();
    rau_out_if out_ch();

    rational_arithmetic_unit #(.WIDTH(32)) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    t_operands        pending_ops[$];
    t_fraction_result expected_results[$];
    int  n_errors   = 0;
    int  n_results  = 0;
    bit  quiet_mode = 0;
    int  hold_cycles = 0;
    bit  in_fire    = 0;

    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
        logic [63:0] t;
        while (y != 0) begin
            t = x % y;
            x = y;
            y = t;
        end
        return x;
    endfunction

    // signed-magnitude sum
    function automatic logic [63:0] sm_sum(bit s1, logic [63:0] m1, bit s2,
                                           logic [63:0] m2, output bit sr);
        if (s1 == s2) begin
            sr = s1;
            return m1 + m2;
        end
        if (m1 >= m2) begin
            sr = (m1 == m2) ? 1'b0 : s1;
            return m1 - m2;
        end
        sr = s2;
        return m2 - m1;
    endfunction

    function automatic logic [63:0] mag32(logic signed [31:0] v);
        return v[31] ? 64'(-64'(signed'(v))) : 64'(v);
    endfunction

    function automatic t_fraction_result compute_fraction(t_operands op);
        t_fraction_result r;
        logic [63:0] an, ad, bn, bd, dm, rn, rd, g, lim;
        bit sa, sb, ds, rs;
        t_status st;
        an = mag32(op.a_num);
        ad = mag32(op.a_den);
        bn = mag32(op.b_num);
        bd = mag32(op.b_den);
        r = '{default: '0};
        if (ad == 0 || bd == 0) begin
            r.status = ST_ZDEN;
            return r;
        end
        sa = (an != 0) && (op.a_num[31] != op.a_den[31]);
        sb = (bn != 0) && (op.b_num[31] != op.b_den[31]);
        dm = sm_sum(sa, an * bd, !sb, bn * ad, ds);
        r.equal = (dm == 0);
        r.greater = (dm != 0) && !ds;
        r.less = (dm != 0) && ds;
        st = ST_OK;
        rn = 0;
        rd = 1;
        rs = 0;
        case (op.command)
            CMD_ADD: begin
                rn = sm_sum(sa, an * bd, sb, bn * ad, rs);
                rd = ad * bd;
            end
            CMD_MUL: begin
                rn = an * bn;
                rs = (rn != 0) && (sa != sb);
                rd = ad * bd;
            end
            CMD_DIV: begin
                if (bn == 0) begin
                    st = ST_DIV0;
                end else begin
                    rn = an * bd;
                    rs = (rn != 0) && (sa != sb);
                    rd = ad * bn;
                end
            end
            default: begin
                rn = dm;
                rs = ds;
                rd = ad * bd;
            end
        endcase
        if (st == ST_OK) begin
            g = gcd64(rn, rd);
            lim = 64'd1 << 31;
            rn = rn / g;
            rd = rd / g;
            if (rn > (rs ? lim : lim - 1) || rd > lim - 1)
                st = ST_OVF;
        end
        if (st == ST_OK) begin
            r.res_num = rs ? 32'(-rn) : 32'(rn);
            r.res_den = 31'(rd);
        end
        r.status = st;
        return r;
    endfunction

    function automatic logic [31:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'hffff_ffff;
            3: return 32'(signed'($urandom_range(0, 6)) - 3);
            4, 5: return 32'(signed'($urandom_range(0, 200)) - 100);
            6: return 32'(signed'($urandom_range(0, 65535)) - 32768);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_op(logic [2:0] c, logic [31:0] an, logic [31:0] ad,
                          logic [31:0] bn, logic [31:0] bd);
        t_operands op;
        op.command = c;
        op.a_num = an;
        op.a_den = ad;
        op.b_num = bn;
        op.b_den = bd;
        pending_ops.push_back(op);
    endtask

    // input handshake seen at the rising edge
    always @(posedge i_clk) begin
        in_fire = i_rst_n && in_ch.valid && in_ch.ready;
    end

    // driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_fire) begin
            if (pending_ops.size() > 0 && (quiet_mode || $urandom_range(0, 99) >= 6)) begin
                t_operands op;
                op = pending_ops.pop_front();
                expected_results.push_back(compute_fraction(op));
                in_ch.valid   <= 1'b1;
                in_ch.command <= op.command;
                in_ch.a_num   <= op.a_num;
                in_ch.a_den   <= op.a_den;
                in_ch.b_num   <= op.b_num;
                in_ch.b_den   <= op.b_den;
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // ready is precomputed so the sampled value matches the handshake
    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= quiet_mode || $urandom_range(0, 99) >= 6;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            t_fraction_result e;
            if (expected_results.size() == 0) begin
                $error("unexpected result word");
                n_errors++;
            end else begin
                e = expected_results.pop_front();
                n_results++;
                if (out_ch.res_num !== e.res_num) begin
                    $error("res_num exp %0d got %0d", e.res_num, out_ch.res_num);
                    n_errors++;
                end
                if (out_ch.res_den !== e.res_den) begin
                    $error("res_den exp %0d got %0d", e.res_den, out_ch.res_den);
                    n_errors++;
                end
                if (out_ch.greater !== e.greater) begin
                    $error("greater exp %0b got %0b", e.greater, out_ch.greater);
                    n_errors++;
                end
                if (out_ch.less !== e.less) begin
                    $error("less exp %0b got %0b", e.less, out_ch.less);
                    n_errors++;
                end
                if (out_ch.equal !== e.equal) begin
                    $error("equal exp %0b got %0b", e.equal, out_ch.equal);
                    n_errors++;
                end
                if (out_ch.status !== e.status) begin
                    $error("status exp %0d got %0d", e.status, out_ch.status);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        #(20ns * 1500 * 2000);
        $display("Test completed with failures");
        $finish;
    end

    initial begin
        int directed_n;
        in_ch.valid = 1'b0;
        in_ch.command = '0;
        in_ch.a_num = '0;
        in_ch.a_den = '0;
        in_ch.b_num = '0;
        in_ch.b_den = '0;
        out_ch.ready = 1'b0;
        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        add_op(CMD_ADD, 1, 2, 1, 3);
        add_op(CMD_SUB, 1, 2, 1, 2);
        add_op(CMD_MUL, -3, 4, 2, -9);
        add_op(CMD_DIV, 5, 7, 0, 3);
        add_op(CMD_DIV, 5, -7, -2, 3);
        add_op(CMD_CMP, 1, 3, 2, 6);
        add_op(CMD_CMP, -1, 3, 1, 3);
        add_op(CMD_ADD, 1, 0, 1, 1);
        add_op(CMD_DIV, 1, 1, 0, 0);
        add_op(3'd5, 7, 3, 2, 5);
        add_op(3'd6, 2, 3, 7, 5);
        add_op(3'd7, 0, -5, 0, 9);
        add_op(CMD_MUL, 32'h8000_0000, 1, 32'hffff_ffff, 1);
        add_op(CMD_MUL, 32'h8000_0000, 1, 1, 1);
        add_op(CMD_ADD, 32'h7fff_ffff, 1, 1, 1);
        add_op(CMD_ADD, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
        add_op(CMD_SUB, 1, 32'h7fff_ffff, 1, 32'h7fff_fffe);
        add_op(CMD_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        add_op(CMD_SUB, 0, 32'h8000_0000, 0, 1);
        add_op(CMD_DIV, 32'hffff_ffff, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        directed_n = pending_ops.size();
        while (pending_ops.size() > 0 || in_ch.valid) @(posedge i_clk);

        // long receiver stall to back up the unit
        @(negedge i_clk);
        hold_cycles = 2000;
        for (int i = 0; i < 1500; i++) begin
            if (i == 300) begin
                while (pending_ops.size() > 0) @(posedge i_clk);
                quiet_mode = 1;
            end
            if (i == 600) begin
                while (pending_ops.size() > 0) @(posedge i_clk);
                quiet_mode = 0;
            end
            add_op(3'($urandom_range(0, 7) == 7 ? $urandom_range(5, 7) : $urandom_range(0, 4)),
                   pick_value(), pick_value(), pick_value(), pick_value());
        end
        while (pending_ops.size() > 0 || in_ch.valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        $display("Covered %0d words: %0d directed, random add/sub/mul/div/compare",
                 n_results, directed_n);
        $display("including zero denominators, divide by zero and overflow, with stalls.");
        if (n_errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

/* sim.f */
+incdir+hdl
hdl/rau_pkg.sv
hdl/rau_if.sv
hdl/rau_fifo.sv
hdl/rau_front.sv
hdl/rau_back.sv
hdl/rational_arithmetic_unit.sv
hdl/rau_checker.sv
tb/testbench.sv
